// ===== hdl/ofsw_pkg.sv =====
// Shared types and constants of the oscillator frequency to serial word unit.
package ofsw_pkg;

    localparam int WORD_W = 16;
    localparam int OCT_W = 4;
    localparam int DAC_W = 10;
    localparam int CNF_W = 2;
    localparam int QUO_W = 12;
    localparam int NUM_W = 38;
    localparam int OCT_MAX = 15;

    localparam logic [31:0] OCT_BASE_HZ = 32'd1039;
    localparam logic [11:0] DAC_NUM = 12'd2078;
    localparam logic [QUO_W-1:0] DAC_OFFSET = 12'd2048;
    localparam logic [QUO_W-1:0] DAC_MAX = 12'd1023;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } word_beat_t;

endpackage

// ===== hdl/ofsw_front.sv =====
// Front end: takes a frequency, finds the octave and runs the DAC division to build the word.
module ofsw_front
    import ofsw_pkg::*;
#(
    parameter int FREQ_WIDTH = 26
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [FREQ_WIDTH-1:0] freq_hz,
    input  logic [CNF_W-1:0]      cnf_bits,
    output word_beat_t            beat_out,
    input  logic                  beat_full
);

    localparam int W = (FREQ_WIDTH + QUO_W > NUM_W) ? FREQ_WIDTH + QUO_W : NUM_W;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

    state_t           state_reg, state_next;
    logic             low_reg, low_next;
    logic [OCT_W-1:0] oct_reg, oct_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     d_reg, d_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic [3:0]       cnt_reg, cnt_next;

    logic [31:0]      f_ext;
    logic [OCT_W-1:0] oct_calc;
    logic [W-1:0]     num_start;
    logic             ge;
    logic [W-1:0]     rem_sub;
    logic [QUO_W-1:0] diff;
    logic [DAC_W-1:0] dac;

    // The octave is the number of doublings of the base frequency that still fit in f.
    always_comb
    begin
        f_ext = 32'(freq_hz);
        oct_calc = '0;
        for (int k = 1; k <= OCT_MAX; k++)
        begin
            if (f_ext >= (OCT_BASE_HZ << k))
            begin
                oct_calc = oct_calc + 4'd1;
            end
        end
    end

    // Ceiling division is done as a floor division of num + f - 1.
    assign num_start = (W'(DAC_NUM) << (oct_calc + 5'd10)) + W'(freq_hz) - W'(1);

    assign ge = (rem_reg >= d_reg);
    assign rem_sub = rem_reg - d_reg;

    always_comb
    begin
        diff = DAC_OFFSET - q_reg;
        if (low_reg || (q_reg >= DAC_OFFSET))
        begin
            dac = '0;
        end
        else if (diff > DAC_MAX)
        begin
            dac = DAC_MAX[DAC_W-1:0];
        end
        else
        begin
            dac = diff[DAC_W-1:0];
        end
    end

    assign beat_out.valid = (state_reg == S_DONE);
    assign beat_out.word = {(low_reg ? 4'd0 : oct_reg), dac, cnf_bits};
    assign full = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        low_next = low_reg;
        oct_next = oct_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (push)
                begin
                    low_next = (f_ext < OCT_BASE_HZ);
                    oct_next = oct_calc;
                    rem_next = num_start;
                    d_next = W'(freq_hz) << (QUO_W - 1);
                    q_next = '0;
                    cnt_next = 4'(QUO_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // One restoring division step per cycle, quotient bit by bit from the top.
                rem_next = ge ? rem_sub : rem_reg;
                q_next = {q_reg[QUO_W-2:0], ge};
                d_next = d_reg >> 1;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!beat_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            low_reg <= 1'b0;
            oct_reg <= '0;
            rem_reg <= '0;
            d_reg <= '0;
            q_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            low_reg <= low_next;
            oct_reg <= oct_next;
            rem_reg <= rem_next;
            d_reg <= d_next;
            q_reg <= q_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    // With f at or above the octave base, the rounded-up quotient never passes 2048.
    a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !low_reg) |-> (q_reg <= DAC_OFFSET))
        else $error("DAC quotient out of range");
`endif

endmodule

// ===== hdl/ofsw_fifo.sv =====
// Two-entry queue of packed words between the front and back ends.
module ofsw_fifo
    import ofsw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  word_beat_t in_beat,
    output logic       full,
    output word_beat_t out_beat,
    input  logic       pop
);

    logic [WORD_W-1:0] entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign full = (count_reg == 2'd2);
    assign out_beat.valid = (count_reg != 2'd0);
    assign out_beat.word = entry_reg[rd_ptr_reg];

    assign do_wr = in_beat.valid && !full;
    assign do_rd = pop && out_beat.valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= in_beat.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    // The fill count and the pointers must agree: equal pointers mean empty or full.
    a_fifo_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

// ===== hdl/ofsw_back.sv =====
// Back end: shifts each packed word out one bit per beat, most significant bit first.
module ofsw_back
    import ofsw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  word_beat_t        q_beat,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic              serial_bit,
    output logic [3:0]        bit_index,
    output logic [WORD_W-1:0] control_word,
    output logic              last_bit
);

    logic              busy_reg, busy_next;
    logic [3:0]        idx_reg, idx_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              done_word;

    assign empty = !busy_reg;
    assign serial_bit = word_reg[idx_reg];
    assign bit_index = idx_reg;
    assign control_word = word_reg;
    assign last_bit = (idx_reg == 4'd0);

    // The next word is loaded in the same cycle that the last bit of the current one leaves.
    assign done_word = !busy_reg || (pop && idx_reg == 4'd0);
    assign q_pop = q_beat.valid && done_word;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next = idx_reg;
        word_next = word_reg;
        if (done_word)
        begin
            busy_next = q_beat.valid;
            if (q_beat.valid)
            begin
                word_next = q_beat.word;
                idx_next = 4'(WORD_W - 1);
            end
        end
        else if (pop)
        begin
            idx_next = idx_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !pop) |=> (busy_reg && $stable(idx_reg) && $stable(word_reg)))
        else $error("result changed while stalled");

    a_bit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && pop && idx_reg != 4'd0) |=> (idx_reg == $past(idx_reg) - 4'd1))
        else $error("bit index skipped");

    a_new_word_start: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (busy_reg && idx_reg == 4'(WORD_W - 1)))
        else $error("word not started at its top bit");
`endif

endmodule

// ===== hdl/oscillator_freq_to_serial_word_unit.sv =====
// Top level of the oscillator frequency to serial word unit.
// Each frequency in hertz becomes a 16-bit word {octave[3:0], dac[9:0], cnf_bits[1:0]}
// that is delivered as 16 result beats, bit 15 first, one bit per cycle when pop is held.
// The octave is the largest n in 0..15 with 1039*2^n <= f, and the DAC value is
// 2048 - ceil(2078*2^(10+n)/f) clamped to 0..1023; frequencies below 1039 Hz give zeros.
// The front end runs each frequency through its 12-step restoring divider and takes no
// new one until its word enters the two-word queue, which separates the divider from the
// serializer; at full rate the intake is limited by the one-bit-per-cycle output.
// cnf_bits is written through the cfg channel, by the user only while no word is in flight;
// the block does not enforce this. It resets to 0.
module oscillator_freq_to_serial_word_unit
    import ofsw_pkg::*;
#(
    parameter int FREQ_WIDTH = 26
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [FREQ_WIDTH-1:0] freq_hz,
    output logic                  empty,
    input  logic                  pop,
    output logic                  serial_bit,
    output logic [3:0]            bit_index,
    output logic [WORD_W-1:0]     control_word,
    output logic                  last_bit,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNF_W-1:0]      cfg_data
);

    logic [CNF_W-1:0] cnf_reg;
    word_beat_t       front_beat;
    word_beat_t       queue_beat;
    logic             queue_full;
    logic             queue_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnf_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cnf_reg <= cfg_data;
        end
    end

    ofsw_front #(
        .FREQ_WIDTH (FREQ_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .freq_hz   (freq_hz),
        .cnf_bits  (cnf_reg),
        .beat_out  (front_beat),
        .beat_full (queue_full)
    );

    ofsw_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (front_beat),
        .full     (queue_full),
        .out_beat (queue_beat),
        .pop      (queue_pop)
    );

    ofsw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_beat       (queue_beat),
        .q_pop        (queue_pop),
        .empty        (empty),
        .pop          (pop),
        .serial_bit   (serial_bit),
        .bit_index    (bit_index),
        .control_word (control_word),
        .last_bit     (last_bit)
    );

endmodule
